@@ hdl/stq_pkg.sv @@
// shared constants, codes and types of the sorted expiry timer queue
package stq_pkg;

   localparam int TIMERS_DEF   = 16;
   localparam int REPORT_CAP   = 16;
   localparam int CNT_W        = 5;
   localparam int ID_W         = 8;
   localparam int TIME_W       = 32;

   // request codes
   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_CHANGE = 2'd1;
   localparam logic [1:0] REQ_REMOVE = 2'd2;
   localparam logic [1:0] REQ_TICK   = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_ABSENT  = 2'd2;
   localparam logic [1:0] ST_PRESENT = 2'd3;

   typedef struct packed {
      logic [TIME_W-1:0] when;
      logic [ID_W-1:0]   id;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SC_RD,
      S_SC_CK,
      S_DECIDE,
      S_DN_RD,
      S_DN_WR,
      S_UP_RD,
      S_UP_WR,
      S_PUT,
      S_RESP,
      S_T_RD,
      S_T_CK
   } state_type;

endpackage

@@ hdl/stq_ifs.sv @@
// request and response channel interfaces
interface stq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [7:0]  timer_id;
   logic [31:0] expire_time;
   logic [31:0] current_time;
   modport source (output valid, req_type, timer_id, expire_time, current_time, input ready);
   modport sink   (input valid, req_type, timer_id, expire_time, current_time, output ready);
endinterface

interface stq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        expired_valid;
   logic [7:0]  expired_id;
   logic [31:0] expired_when;
   logic [4:0]  active_count;
   logic        last;
   modport source (output valid, status, expired_valid, expired_id, expired_when,
                   active_count, last, input ready);
   modport sink   (input valid, status, expired_valid, expired_id, expired_when,
                   active_count, last, output ready);
endinterface

@@ hdl/sorted_expiry_timer_queue.sv @@
// sorted expiry timer queue top level
// Insert/change/remove: a scan over every held timer, then the moved entries are shifted
// one by one through the entry memory; a change removes, scans again and reinserts.
// Tick: each reported timer is removed from the head, which shifts the list.
// One item is worked at a time; a finished result waits in an output register.
// Synchronous reset empties the queue; memory contents are not cleared.
module sorted_expiry_timer_queue #(
   parameter int TIMERS = stq_pkg::TIMERS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   stq_req_if.sink      req_chan,
   stq_rsp_if.source    rsp_chan
);

   localparam int AW = $clog2(TIMERS);
   localparam int IW = $clog2(TIMERS + 1);

   stq_pkg::state_type state_ff, state_in;
   logic [1:0]         op_ff, op_in;
   logic [7:0]         id_ff, id_in;
   logic [31:0]        when_ff, when_in, now_ff, now_in;
   logic [IW-1:0]      occ_ff, occ_in, idx_ff, idx_in;
   logic [IW-1:0]      fpos_ff, fpos_in, ipos_ff, ipos_in;
   logic               fnd_ff, fnd_in, iset_ff, iset_in, ph2_ff, ph2_in;
   logic [1:0]         stat_ff, stat_in;
   logic [4:0]         n_ff, n_in;
   logic               stg_ff, stg_in;
   stq_pkg::entry_type stg_e_ff, stg_e_in;
   logic [IW-1:0]      stg_cnt_ff, stg_cnt_in;

   logic               rv_ff, rv_in;
   logic [1:0]         r_stat_ff, r_stat_in;
   logic               r_ev_ff, r_ev_in, r_last_ff, r_last_in;
   logic [7:0]         r_id_ff, r_id_in;
   logic [31:0]        r_when_ff, r_when_in;
   logic [4:0]         r_cnt_ff, r_cnt_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   stq_pkg::entry_type wr_data, rd_data;
   logic               out_free;
   logic [IW:0]        idx_p1;

   stq_store #(.TIMERS(TIMERS)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free       = !rv_ff || rsp_chan.ready;
   assign idx_p1         = {1'b0, idx_ff} + {{IW{1'b0}}, 1'b1};
   assign req_chan.ready = (state_ff == stq_pkg::S_IDLE);

   // response port
   assign rsp_chan.valid         = rv_ff;
   assign rsp_chan.status        = r_stat_ff;
   assign rsp_chan.expired_valid = r_ev_ff;
   assign rsp_chan.expired_id    = r_id_ff;
   assign rsp_chan.expired_when  = r_when_ff;
   assign rsp_chan.active_count  = r_cnt_ff;
   assign rsp_chan.last          = r_last_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stq_pkg::S_IDLE;
         occ_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
         rv_ff    <= rv_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      id_ff      <= id_in;
      when_ff    <= when_in;
      now_ff     <= now_in;
      idx_ff     <= idx_in;
      fpos_ff    <= fpos_in;
      ipos_ff    <= ipos_in;
      fnd_ff     <= fnd_in;
      iset_ff    <= iset_in;
      ph2_ff     <= ph2_in;
      stat_ff    <= stat_in;
      n_ff       <= n_in;
      stg_ff     <= stg_in;
      stg_e_ff   <= stg_e_in;
      stg_cnt_ff <= stg_cnt_in;
      r_stat_ff  <= r_stat_in;
      r_ev_ff    <= r_ev_in;
      r_last_ff  <= r_last_in;
      r_id_ff    <= r_id_in;
      r_when_ff  <= r_when_in;
      r_cnt_ff   <= r_cnt_in;
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      id_in      = id_ff;
      when_in    = when_ff;
      now_in     = now_ff;
      occ_in     = occ_ff;
      idx_in     = idx_ff;
      fpos_in    = fpos_ff;
      ipos_in    = ipos_ff;
      fnd_in     = fnd_ff;
      iset_in    = iset_ff;
      ph2_in     = ph2_ff;
      stat_in    = stat_ff;
      n_in       = n_ff;
      stg_in     = stg_ff;
      stg_e_in   = stg_e_ff;
      stg_cnt_in = stg_cnt_ff;
      rv_in      = rv_ff && !rsp_chan.ready;
      r_stat_in  = r_stat_ff;
      r_ev_in    = r_ev_ff;
      r_last_in  = r_last_ff;
      r_id_in    = r_id_ff;
      r_when_in  = r_when_ff;
      r_cnt_in   = r_cnt_ff;
      wr_en      = 1'b0;
      wr_addr    = idx_ff[AW-1:0];
      wr_data    = rd_data;
      rd_addr    = idx_ff[AW-1:0];

      unique case (state_ff)
         stq_pkg::S_IDLE: begin
            if (req_chan.valid) begin
               op_in   = req_chan.req_type;
               id_in   = req_chan.timer_id;
               when_in = req_chan.expire_time;
               now_in  = req_chan.current_time;
               idx_in  = '0;
               fnd_in  = 1'b0;
               iset_in = 1'b0;
               ipos_in = occ_ff;
               ph2_in  = 1'b0;
               stat_in = stq_pkg::ST_OK;
               n_in    = '0;
               stg_in  = 1'b0;
               state_in = (req_chan.req_type == stq_pkg::REQ_TICK) ?
                          stq_pkg::S_T_RD : stq_pkg::S_SC_RD;
            end
         end
         // scan for the id and the sorted place
         stq_pkg::S_SC_RD: begin
            state_in = (idx_ff == occ_ff) ? stq_pkg::S_DECIDE : stq_pkg::S_SC_CK;
         end
         stq_pkg::S_SC_CK: begin
            if (rd_data.id == id_ff && !fnd_ff) begin
               fnd_in  = 1'b1;
               fpos_in = idx_ff;
            end
            if (rd_data.when > when_ff && !iset_ff) begin
               iset_in = 1'b1;
               ipos_in = idx_ff;
            end
            idx_in   = idx_p1[IW-1:0];
            state_in = stq_pkg::S_SC_RD;
         end
         stq_pkg::S_DECIDE: begin
            if (op_ff == stq_pkg::REQ_INSERT || ph2_ff) begin
               if (!ph2_ff && fnd_ff) begin
                  stat_in  = stq_pkg::ST_PRESENT;
                  state_in = stq_pkg::S_RESP;
               end else if (occ_ff == IW'(TIMERS)) begin
                  stat_in  = stq_pkg::ST_FULL;
                  state_in = stq_pkg::S_RESP;
               end else begin
                  idx_in   = occ_ff;
                  state_in = stq_pkg::S_UP_RD;
               end
            end else if (!fnd_ff) begin
               stat_in  = stq_pkg::ST_ABSENT;
               state_in = stq_pkg::S_RESP;
            end else begin
               idx_in   = fpos_ff;
               state_in = stq_pkg::S_DN_RD;
            end
         end
         // close the gap left by a removed entry
         stq_pkg::S_DN_RD: begin
            rd_addr = idx_p1[AW-1:0];
            if (idx_p1 >= {1'b0, occ_ff}) begin
               occ_in = occ_ff - IW'(1);
               if (op_ff == stq_pkg::REQ_TICK) begin
                  state_in = stq_pkg::S_T_RD;
               end else if (op_ff == stq_pkg::REQ_CHANGE) begin
                  ph2_in   = 1'b1;
                  idx_in   = '0;
                  iset_in  = 1'b0;
                  ipos_in  = occ_ff - IW'(1);
                  state_in = stq_pkg::S_SC_RD;
               end else begin
                  state_in = stq_pkg::S_RESP;
               end
            end else begin
               state_in = stq_pkg::S_DN_WR;
            end
         end
         stq_pkg::S_DN_WR: begin
            wr_en    = 1'b1;
            idx_in   = idx_p1[IW-1:0];
            state_in = stq_pkg::S_DN_RD;
         end
         // open a hole at the sorted place
         stq_pkg::S_UP_RD: begin
            rd_addr = AW'(idx_ff - IW'(1));
            state_in = (idx_ff == ipos_ff) ? stq_pkg::S_PUT : stq_pkg::S_UP_WR;
         end
         stq_pkg::S_UP_WR: begin
            wr_en    = 1'b1;
            idx_in   = idx_ff - IW'(1);
            state_in = stq_pkg::S_UP_RD;
         end
         stq_pkg::S_PUT: begin
            wr_en        = 1'b1;
            wr_addr      = ipos_ff[AW-1:0];
            wr_data.when = when_ff;
            wr_data.id   = id_ff;
            occ_in       = occ_ff + IW'(1);
            state_in     = stq_pkg::S_RESP;
         end
         stq_pkg::S_RESP: begin
            if (out_free) begin
               rv_in     = 1'b1;
               r_stat_in = stat_ff;
               r_ev_in   = 1'b0;
               r_id_in   = '0;
               r_when_in = '0;
               r_cnt_in  = 5'(occ_ff);
               r_last_in = 1'b1;
               state_in  = stq_pkg::S_IDLE;
            end
         end
         // tick: look at the head
         stq_pkg::S_T_RD: begin
            rd_addr  = '0;
            state_in = stq_pkg::S_T_CK;
         end
         stq_pkg::S_T_CK: begin
            rd_addr = '0;
            if (occ_ff != '0 && rd_data.when <= now_ff &&
                {1'b0, n_ff} < 6'(stq_pkg::REPORT_CAP)) begin
               if (!stg_ff || out_free) begin
                  if (stg_ff) begin
                     rv_in     = 1'b1;
                     r_stat_in = stq_pkg::ST_OK;
                     r_ev_in   = 1'b1;
                     r_id_in   = stg_e_ff.id;
                     r_when_in = stg_e_ff.when;
                     r_cnt_in  = 5'(stg_cnt_ff);
                     r_last_in = 1'b0;
                  end
                  stg_in     = 1'b1;
                  stg_e_in   = rd_data;
                  stg_cnt_in = occ_ff - IW'(1);
                  n_in       = n_ff + 5'd1;
                  idx_in     = '0;
                  state_in   = stq_pkg::S_DN_RD;
               end
            end else if (out_free) begin
               rv_in     = 1'b1;
               r_stat_in = stq_pkg::ST_OK;
               r_ev_in   = stg_ff;
               r_id_in   = stg_ff ? stg_e_ff.id : '0;
               r_when_in = stg_ff ? stg_e_ff.when : '0;
               r_cnt_in  = stg_ff ? 5'(stg_cnt_ff) : 5'(occ_ff);
               r_last_in = 1'b1;
               state_in  = stq_pkg::S_IDLE;
            end
         end
         default: state_in = stq_pkg::S_IDLE;
      endcase
   end

endmodule

@@ hdl/stq_store.sv @@
// timer entry memory, one write and one registered read per cycle
module stq_store #(
   parameter int TIMERS = stq_pkg::TIMERS_DEF
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(TIMERS)-1:0]  wr_addr,
   input  stq_pkg::entry_type         wr_data,
   input  logic [$clog2(TIMERS)-1:0]  rd_addr,
   output stq_pkg::entry_type         rd_data
);

   stq_pkg::entry_type mem [TIMERS];
   stq_pkg::entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ verif/stq_tb_ifs.sv @@
`timescale 1ns / 100ps
// stimulus table record type for the timer queue testbench
package stq_tb_types;
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  id;
      logic [31:0] expiry;
      logic [31:0] now;
      logic        has_rsp;
      logic [1:0]  rsp_status;
   } stim_row_type;
endpackage

@@ verif/tb_sorted_expiry_timer_queue.sv @@
`timescale 1ns / 100ps
// self-checking testbench of the sorted expiry timer queue
module tb_sorted_expiry_timer_queue;

   typedef struct packed {
      logic [1:0]  status;
      logic        expired_valid;
      logic [7:0]  expired_id;
      logic [31:0] expired_when;
      logic [4:0]  active_count;
      logic        last;
   } result_type;

   localparam int N_TIMERS = stq_pkg::TIMERS_DEF;
   localparam int N_RANDOM = 360;
   localparam int IDLE_LIMIT = 20000;

   logic clock;
   logic reset;
   stq_req_if req_chan ();
   stq_rsp_if rsp_chan ();

   sorted_expiry_timer_queue #(.TIMERS(N_TIMERS)) uut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan)
   );

   // queue contents as the predictor sees them
   logic [31:0] shadow_expiry [N_TIMERS];
   logic [7:0]  shadow_id [N_TIMERS];
   int          shadow_count;

   result_type  pending_results [$];
   int          mismatch_count;
   int          idle_cycles;
   logic [31:0] clock_now;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int find_timer(logic [7:0] id);
      for (int i = 0; i < shadow_count; i++)
         if (shadow_id[i] == id) return i;
      return -1;
   endfunction

   function automatic void drop_timer(int pos);
      for (int i = pos; i + 1 < shadow_count; i++) begin
         shadow_expiry[i] = shadow_expiry[i+1];
         shadow_id[i] = shadow_id[i+1];
      end
      if (shadow_count > 0) shadow_count--;
   endfunction

   function automatic void place_timer(logic [7:0] id, logic [31:0] expiry);
      int pos;
      pos = 0;
      if (shadow_count >= N_TIMERS) return;
      while (pos < shadow_count && shadow_expiry[pos] <= expiry) pos++;
      for (int i = shadow_count; i > pos; i--) begin
         shadow_expiry[i] = shadow_expiry[i-1];
         shadow_id[i] = shadow_id[i-1];
      end
      shadow_expiry[pos] = expiry;
      shadow_id[pos] = id;
      shadow_count++;
   endfunction

   function automatic result_type make_result(logic [1:0] st, logic v, logic [7:0] id,
                                              logic [31:0] w, logic l);
      result_type r;
      r.status = st;
      r.expired_valid = v;
      r.expired_id = id;
      r.expired_when = w;
      r.active_count = shadow_count[4:0];
      r.last = l;
      return r;
   endfunction

   // work out the results of one accepted request
   function automatic void predict_request(logic [1:0] kind, logic [7:0] id,
                                           logic [31:0] expiry, logic [31:0] now);
      int pos;
      int reported;
      logic [1:0] st;
      logic [7:0] h;
      logic [31:0] e;
      result_type r;
      st = stq_pkg::ST_OK;
      reported = 0;
      if (kind == stq_pkg::REQ_TICK) begin
         while (reported < stq_pkg::REPORT_CAP && shadow_count > 0 &&
                shadow_expiry[0] <= now) begin
            h = shadow_id[0];
            e = shadow_expiry[0];
            drop_timer(0);
            pending_results.push_back(make_result(stq_pkg::ST_OK, 1'b1, h, e, 1'b0));
            reported++;
         end
         if (reported == 0) begin
            pending_results.push_back(make_result(stq_pkg::ST_OK, 1'b0, 8'd0, 32'd0, 1'b1));
         end else begin
            r = pending_results.pop_back();
            r.last = 1'b1;
            pending_results.push_back(r);
         end
         return;
      end
      pos = find_timer(id);
      case (kind)
         stq_pkg::REQ_INSERT: begin
            if (pos >= 0) st = stq_pkg::ST_PRESENT;
            else if (shadow_count >= N_TIMERS) st = stq_pkg::ST_FULL;
            else place_timer(id, expiry);
         end
         stq_pkg::REQ_CHANGE: begin
            if (pos < 0) st = stq_pkg::ST_ABSENT;
            else begin
               drop_timer(pos);
               place_timer(id, expiry);
            end
         end
         default: begin
            if (pos < 0) st = stq_pkg::ST_ABSENT;
            else drop_timer(pos);
         end
      endcase
      pending_results.push_back(make_result(st, 1'b0, 8'd0, 32'd0, 1'b1));
   endfunction

   function automatic int random_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // send one request and record its prediction at acceptance
   task automatic send_request(logic [1:0] kind, logic [7:0] id, logic [31:0] expiry,
                               logic [31:0] now);
      int gap;
      gap = random_gap();
      @(negedge clock);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.req_type <= kind;
      req_chan.timer_id <= id;
      req_chan.expire_time <= expiry;
      req_chan.current_time <= now;
      do @(posedge clock); while (!req_chan.ready);
      predict_request(kind, id, expiry, now);
   endtask

   // directed table: typed status where it can be read off directly
   stq_tb_types::stim_row_type directed_rows [] = '{
      '{stq_pkg::REQ_TICK,   8'h00, 32'h0,         32'hFFFF_FFFF, 1'b1, stq_pkg::ST_OK},
      '{stq_pkg::REQ_REMOVE, 8'h12, 32'h0,         32'h0,         1'b1, stq_pkg::ST_ABSENT},
      '{stq_pkg::REQ_CHANGE, 8'hFF, 32'h5,         32'h0,         1'b1, stq_pkg::ST_ABSENT},
      '{stq_pkg::REQ_INSERT, 8'h00, 32'h0,         32'h0,         1'b1, stq_pkg::ST_OK},
      '{stq_pkg::REQ_INSERT, 8'h00, 32'h7,         32'h0,         1'b1, stq_pkg::ST_PRESENT},
      '{stq_pkg::REQ_INSERT, 8'hFF, 32'hFFFF_FFFF, 32'h0,         1'b1, stq_pkg::ST_OK},
      '{stq_pkg::REQ_INSERT, 8'h55, 32'h100,       32'h0,         1'b0, stq_pkg::ST_OK},
      '{stq_pkg::REQ_INSERT, 8'hAA, 32'h100,       32'h0,         1'b0, stq_pkg::ST_OK},
      '{stq_pkg::REQ_CHANGE, 8'h55, 32'h100,       32'h0,         1'b0, stq_pkg::ST_OK},
      '{stq_pkg::REQ_CHANGE, 8'hFF, 32'h1,         32'h0,         1'b0, stq_pkg::ST_OK},
      '{stq_pkg::REQ_CHANGE, 8'h00, 32'hFFFF_FFFF, 32'h0,         1'b0, stq_pkg::ST_OK},
      '{stq_pkg::REQ_TICK,   8'h00, 32'h0,         32'h0FF,       1'b0, stq_pkg::ST_OK},
      '{stq_pkg::REQ_TICK,   8'h00, 32'h0,         32'h100,       1'b0, stq_pkg::ST_OK},
      '{stq_pkg::REQ_REMOVE, 8'h00, 32'h0,         32'h0,         1'b0, stq_pkg::ST_OK},
      '{stq_pkg::REQ_REMOVE, 8'h00, 32'h0,         32'h0,         1'b1, stq_pkg::ST_ABSENT},
      '{stq_pkg::REQ_TICK,   8'h00, 32'h0,         32'hFFFF_FFFF, 1'b0, stq_pkg::ST_OK}
   };

   // fill the table, overflow it, then drain all sixteen in one tick
   task automatic run_directed();
      result_type r;
      for (int i = 0; i < directed_rows.size(); i++) begin
         send_request(directed_rows[i].kind, directed_rows[i].id,
                      directed_rows[i].expiry, directed_rows[i].now);
         if (directed_rows[i].has_rsp) begin
            r = pending_results[$];
            if (r.status != directed_rows[i].rsp_status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("row %0d: predicted status %0d, table says %0d", i, r.status,
                           directed_rows[i].rsp_status);
            end
         end
      end
      for (int i = 0; i < N_TIMERS; i++)
         send_request(stq_pkg::REQ_INSERT, 8'(i + 16), 32'd50, 32'd0);
      send_request(stq_pkg::REQ_INSERT, 8'hC3, 32'd1, 32'd0);
      send_request(stq_pkg::REQ_TICK, 8'd0, 32'd0, 32'd50);
   endtask

   // random traffic: mostly hits on a small id pool with clustered times
   task automatic run_random();
      logic [1:0]  kind;
      logic [7:0]  id;
      logic [31:0] expiry;
      int          pick;
      for (int n = 0; n < N_RANDOM; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) kind = stq_pkg::REQ_INSERT;
         else if (pick < 55) kind = stq_pkg::REQ_CHANGE;
         else if (pick < 70) kind = stq_pkg::REQ_REMOVE;
         else kind = stq_pkg::REQ_TICK;
         if ($urandom_range(0, 9) < 8) id = 8'($urandom_range(0, 23));
         else id = 8'($urandom);
         pick = $urandom_range(0, 9);
         if (pick < 7) expiry = clock_now + $urandom_range(0, 60);
         else if (pick < 9) expiry = $urandom;
         else expiry = 32'hFFFF_FFFF;
         if (kind == stq_pkg::REQ_TICK) begin
            if ($urandom_range(0, 19) == 0) clock_now = $urandom;
            else clock_now = clock_now + $urandom_range(0, 30);
         end
         send_request(kind, id, expiry, clock_now);
      end
   endtask

   // response side: random stalls of varied length
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         repeat (random_gap()) begin
            @(negedge clock);
            rsp_chan.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_chan.ready <= 1'b1;
      end
   end

   // compare each accepted item with the oldest expectation
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{rsp_chan.status, rsp_chan.expired_valid, rsp_chan.expired_id,
                 rsp_chan.expired_when, rsp_chan.active_count, rsp_chan.last};
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %p", got);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("expected %p, got %p", want, got);
            end
         end
      end
   end

   // watchdog on cycles with no accepted item on either side
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("FAIL sorted_expiry_timer_queue");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      idle_cycles = 0;
      mismatch_count = 0;
      clock_now = 32'd0;
      req_chan.valid = 1'b0;
      req_chan.req_type = stq_pkg::REQ_TICK;
      req_chan.timer_id = 8'd0;
      req_chan.expire_time = 32'd0;
      req_chan.current_time = 32'd0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("PASS sorted_expiry_timer_queue");
      end else begin
         $display("FAIL sorted_expiry_timer_queue");
      end
      $finish;
   end

endmodule
